@@ rtl/traction_energy_meter_assert.svh @@
// Assertion macros shared by the checker of traction_energy_meter.
// Needs i_clk and i_rst_n in scope where used.
`ifndef TRACTION_ENERGY_METER_ASSERT_SVH
`define TRACTION_ENERGY_METER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tem assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tem assertion failed");

`endif

@@ rtl/tem_pkg.sv @@
// Shared types and constants of the traction energy meter.
// No dependencies; imported by tem_front, tem_back, tem_div and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tem_pkg;

    localparam int ELAPSED_W  = 16;
    localparam int VOLT_W     = 14;
    localparam int CUR_W      = 14;
    localparam int SPEED_W    = 16;
    localparam int POWER_W    = 20;
    localparam int TOTAL_W    = 47;
    localparam int CONS_W     = 21;
    localparam int THRESH_W   = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    // divider operands: net energy * 1000 over distance
    localparam int DVD_W = 57;
    localparam int DVS_W = 47;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELAPSED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ELAPSED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD  = 2'd2;

    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_RST     = 16'd5000;
    localparam logic [ELAPSED_W-1:0] DEFAULT_ELAPSED_RST = 16'd100;
    localparam logic [THRESH_W-1:0]  DIST_THRESHOLD_RST  = 40'd3600000;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [18:0]        POWER_LIM = 19'd500000;
    localparam logic [CONS_W-1:0]  CONS_LIM  = 21'd1000000;

    // x/100 = (x>>2)/25; ceil(2^32/25), exact for x>>2 below 2^25
    localparam logic [27:0] RECIP_25    = 28'd171798692;
    localparam int          RECIP_SHIFT = 32;

    typedef struct packed {
        logic [ELAPSED_W-1:0]    dt;
        logic [VOLT_W-1:0]       volt;
        logic signed [CUR_W-1:0] cur;
        logic [SPEED_W-1:0]      speed;
    } t_sample;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_POW,
        S_EMUL,
        S_EACC,
        S_DMUL,
        S_DACC,
        S_CMP,
        S_DSTART,
        S_DWAIT,
        S_CSAT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/tem_front.sv @@
// Front end: configuration registers, sample intake and elapsed-time cleanup.
// Depends on tem_pkg; feeds tem_queue.
`timescale 1ns / 1ps
`default_nettype none

module tem_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [tem_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    input  logic [tem_pkg::VOLT_W-1:0]          i_voltage_dv,
    input  logic signed [tem_pkg::CUR_W-1:0]    i_current_da,
    input  logic [tem_pkg::SPEED_W-1:0]         i_speed_ckmh,
    input  logic                                i_cfg_we,
    input  logic [tem_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tem_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                i_q_full,
    output logic                                o_q_wr,
    output tem_pkg::t_sample                    o_q_data,
    output logic [tem_pkg::THRESH_W-1:0]        o_threshold
);
    import tem_pkg::*;

    logic [ELAPSED_W-1:0] r_max_elapsed;
    logic [ELAPSED_W-1:0] r_default_elapsed;
    logic [THRESH_W-1:0]  r_threshold;
    logic                 w_use_default;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_elapsed     <= MAX_ELAPSED_RST;
            r_default_elapsed <= DEFAULT_ELAPSED_RST;
            r_threshold       <= DIST_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ELAPSED:     r_max_elapsed     <= i_cfg_wdata[ELAPSED_W-1:0];
                CFG_DEFAULT_ELAPSED: r_default_elapsed <= i_cfg_wdata[ELAPSED_W-1:0];
                CFG_DIST_THRESHOLD:  r_threshold       <= i_cfg_wdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // zero or oversized tick gap falls back to the default gap
    assign w_use_default = (i_elapsed_ms == '0) || (i_elapsed_ms > r_max_elapsed);

    always_comb begin
        o_q_data.dt    = w_use_default ? r_default_elapsed : i_elapsed_ms;
        o_q_data.volt  = i_voltage_dv;
        o_q_data.cur   = i_current_da;
        o_q_data.speed = i_speed_ckmh;
    end

    assign o_q_wr      = i_push && !i_q_full;
    assign o_threshold = r_threshold;

endmodule

`default_nettype wire

@@ rtl/tem_queue.sv @@
// Small FIFO of cleaned samples between front end and back end.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module tem_queue #(
    parameter int DEPTH = 2,
    parameter int W     = 60
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wr_data,
    input  logic         i_rd,
    output logic [W-1:0] o_rd_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);

endmodule

`default_nettype wire

@@ rtl/tem_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tem_pkg for operand widths and request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module tem_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tem_pkg::t_div_req i_req,
    output tem_pkg::t_div_rsp o_rsp
);
    import tem_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_trial = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_trial[DVS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

@@ rtl/tem_back.sv @@
// Back end: power, energy and distance integration, consumption update, result register.
// Depends on tem_pkg; reads tem_queue and drives tem_div.
`timescale 1ns / 1ps
`default_nettype none

module tem_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  tem_pkg::t_sample                  i_q_data,
    output logic                              o_q_rd,
    input  logic [tem_pkg::THRESH_W-1:0]      i_threshold,
    output tem_pkg::t_div_req                 o_div_req,
    input  tem_pkg::t_div_rsp                 i_div_rsp,
    input  logic                              i_pop,
    output logic                              o_empty,
    output logic signed [tem_pkg::POWER_W-1:0] o_power_w,
    output logic [tem_pkg::TOTAL_W-1:0]       o_consumed_mj,
    output logic [tem_pkg::TOTAL_W-1:0]       o_regenerated_mj,
    output logic [tem_pkg::TOTAL_W-1:0]       o_distance_raw,
    output logic signed [tem_pkg::CONS_W-1:0] o_consumption_c
);
    import tem_pkg::*;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                   input logic [TOTAL_W-1:0] add);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, total} + {1'b0, add};
        return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    endfunction

    t_state r_state, n_state;

    t_sample                    r_smp;
    logic signed [28:0]         r_prod;
    logic                       r_neg;
    logic [52:0]                r_scaled;
    logic [18:0]                r_pmag;
    logic signed [POWER_W-1:0]  r_power;
    logic [34:0]                r_emul;
    logic [31:0]                r_dmul;
    logic [TOTAL_W-1:0]         r_cons;
    logic [TOTAL_W-1:0]         r_regen;
    logic [TOTAL_W-1:0]         r_dist;
    logic signed [CONS_W-1:0]   r_held;
    logic                       r_net_neg;
    logic [DVD_W-1:0]           r_dividend;

    logic                       r_out_valid;
    logic signed [POWER_W-1:0]  r_o_power;
    logic [TOTAL_W-1:0]         r_o_cons;
    logic [TOTAL_W-1:0]         r_o_regen;
    logic [TOTAL_W-1:0]         r_o_dist;
    logic signed [CONS_W-1:0]   r_o_held;

    logic                       w_load_out;
    logic                       w_div_start;
    logic                       w_dist_over;
    logic [28:0]                w_abs;
    logic [20:0]                w_q100;
    logic [18:0]                w_pmag;
    logic                       w_regen_gt;
    logic [TOTAL_W-1:0]         w_net;
    logic [DVD_W-1:0]           w_net_x;
    logic [CONS_W-1:0]          w_cons_mag;

    assign w_abs       = r_prod[28] ? 29'(-r_prod) : 29'(r_prod);
    assign w_q100      = r_scaled[RECIP_SHIFT+20:RECIP_SHIFT];
    assign w_pmag      = (w_q100 > 21'(POWER_LIM)) ? POWER_LIM : w_q100[18:0];
    assign w_dist_over = r_dist > TOTAL_W'(i_threshold);
    assign w_regen_gt  = r_regen > r_cons;
    assign w_net       = w_regen_gt ? (r_regen - r_cons) : (r_cons - r_regen);
    assign w_net_x     = DVD_W'(w_net);
    assign w_cons_mag  = (i_div_rsp.quotient > DVD_W'(CONS_LIM)) ? CONS_LIM
                                                                   : i_div_rsp.quotient[CONS_W-1:0];

    always_comb begin
        n_state     = r_state;
        o_q_rd      = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd  = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL:    n_state = S_SCALE;
            S_SCALE:  n_state = S_POW;
            S_POW:    n_state = S_EMUL;
            S_EMUL:   n_state = S_EACC;
            S_EACC:   n_state = S_DMUL;
            S_DMUL:   n_state = S_DACC;
            S_DACC:   n_state = S_CMP;
            S_CMP:    n_state = w_dist_over ? S_DSTART : S_DONE;
            S_DSTART: begin
                w_div_start = 1'b1;
                n_state     = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_div_rsp.done) begin
                    n_state = S_CSAT;
                end
            end
            S_CSAT:   n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // control state and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cons      <= '0;
            r_regen     <= '0;
            r_dist      <= '0;
            r_held      <= '0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EACC) begin
                if (!r_neg && (r_pmag != '0)) begin
                    r_cons <= sat_add(r_cons, TOTAL_W'(r_emul));
                end else begin
                    r_regen <= sat_add(r_regen, TOTAL_W'(r_emul));
                end
            end
            if (r_state == S_DACC) begin
                r_dist <= sat_add(r_dist, TOTAL_W'(r_dmul));
            end
            if (r_state == S_CSAT) begin
                r_held <= r_net_neg ? -$signed(w_cons_mag) : $signed(w_cons_mag);
            end
        end
    end

    // datapath pipeline registers
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_smp <= i_q_data;
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed({1'b0, r_smp.volt}) * $signed(r_smp.cur);
        end
        if (r_state == S_SCALE) begin
            r_neg    <= r_prod[28];
            r_scaled <= w_abs[26:2] * RECIP_25;
        end
        if (r_state == S_POW) begin
            r_pmag  <= w_pmag;
            r_power <= r_neg ? -$signed({1'b0, w_pmag}) : $signed({1'b0, w_pmag});
        end
        if (r_state == S_EMUL) begin
            r_emul <= r_pmag * r_smp.dt;
        end
        if (r_state == S_DMUL) begin
            r_dmul <= r_smp.speed * r_smp.dt;
        end
        if (r_state == S_CMP) begin
            r_net_neg  <= w_regen_gt;
            // net * 1000 = net * 1024 - net * 16 - net * 8
            r_dividend <= (w_net_x << 10) - (w_net_x << 4) - (w_net_x << 3);
        end
        if (w_load_out) begin
            r_o_power <= r_power;
            r_o_cons  <= r_cons;
            r_o_regen <= r_regen;
            r_o_dist  <= r_dist;
            r_o_held  <= r_held;
        end
    end

    assign o_div_req.start    = w_div_start;
    assign o_div_req.dividend = r_dividend;
    assign o_div_req.divisor  = r_dist;

    assign o_empty          = !r_out_valid;
    assign o_power_w        = r_o_power;
    assign o_consumed_mj    = r_o_cons;
    assign o_regenerated_mj = r_o_regen;
    assign o_distance_raw   = r_o_dist;
    assign o_consumption_c  = r_o_held;

endmodule

`default_nettype wire

@@ rtl/traction_energy_meter.sv @@
// Top level of the traction energy meter: front end, sample FIFO, back end, divider.
// Depends on tem_pkg, tem_front, tem_queue, tem_back and tem_div.
//
// Usage:
//  - Input channel is FIFO-like: a word {elapsed_ms, voltage_dv, current_da,
//    speed_ckmh} is taken at a clock edge with push high and full low.
//  - Result channel is FIFO-like: while empty is low the oldest result word
//    {power_w, consumed_mj, regenerated_mj, distance_raw, consumption_c} is
//    on the ports; pop high with empty low takes it.
//  - Config: i_cfg_we high at a clock edge writes i_cfg_wdata to register i_cfg_idx
//    (0 max_elapsed_ms, 1 default_elapsed_ms, 2 distance_threshold).
//  - The back end reads a word from the FIFO, then multiplies, scales, forms
//    power, updates energy and distance and compares; once the distance is above
//    the threshold, the 57-step restoring divider also runs. The back-end sequencer
//    works one sample at a time and loads its result before it reads the next.
//  - A QUEUE_DEPTH-entry FIFO sits behind the front end, so words are still
//    taken while the back end is busy or a result waits to be popped.
//  - When the receiver stalls, the finished result holds in the output
//    register and the back end waits; full rises once the FIFO fills.
//  - Reset (synchronous, active low) clears totals, FIFO, result; reloads config.
`timescale 1ns / 1ps
`default_nettype none

module traction_energy_meter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [tem_pkg::ELAPSED_W-1:0]       i_elapsed_ms,
    input  logic [tem_pkg::VOLT_W-1:0]          i_voltage_dv,
    input  logic signed [tem_pkg::CUR_W-1:0]    i_current_da,
    input  logic [tem_pkg::SPEED_W-1:0]         i_speed_ckmh,
    input  logic                                pop,
    output logic                                empty,
    output logic signed [tem_pkg::POWER_W-1:0]  o_power_w,
    output logic [tem_pkg::TOTAL_W-1:0]         o_consumed_mj,
    output logic [tem_pkg::TOTAL_W-1:0]         o_regenerated_mj,
    output logic [tem_pkg::TOTAL_W-1:0]         o_distance_raw,
    output logic signed [tem_pkg::CONS_W-1:0]   o_consumption_c,
    input  logic                                i_cfg_we,
    input  logic [tem_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tem_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import tem_pkg::*;

    // front end -> FIFO
    logic                q_wr;
    t_sample             q_wr_data;
    logic                q_full;
    // FIFO -> back end
    logic                q_rd;
    logic [$bits(t_sample)-1:0] q_rd_bits;
    t_sample             q_rd_data;
    logic                q_empty;
    logic [THRESH_W-1:0] threshold;
    // back end <-> divider
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    tem_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_elapsed_ms (i_elapsed_ms),
        .i_voltage_dv (i_voltage_dv),
        .i_current_da (i_current_da),
        .i_speed_ckmh (i_speed_ckmh),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_full     (q_full),
        .o_q_wr       (q_wr),
        .o_q_data     (q_wr_data),
        .o_threshold  (threshold)
    );

    tem_queue #(
        .DEPTH (QUEUE_DEPTH),
        .W     ($bits(t_sample))
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_bits),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    assign q_rd_data = t_sample'(q_rd_bits);

    tem_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_rd_data),
        .o_q_rd           (q_rd),
        .i_threshold      (threshold),
        .o_div_req        (div_req),
        .i_div_rsp        (div_rsp),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_power_w        (o_power_w),
        .o_consumed_mj    (o_consumed_mj),
        .o_regenerated_mj (o_regenerated_mj),
        .o_distance_raw   (o_distance_raw),
        .o_consumption_c  (o_consumption_c)
    );

    tem_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign full = q_full;

endmodule

`default_nettype wire

@@ rtl/tem_checker.sv @@
// Port-level checker for traction_energy_meter, bound to the top level.
// Depends on traction_energy_meter_assert.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "traction_energy_meter_assert.svh"

module tem_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                pop,
    input  logic                                empty,
    input  logic signed [tem_pkg::POWER_W-1:0]  o_power_w,
    input  logic [tem_pkg::TOTAL_W-1:0]         o_consumed_mj,
    input  logic signed [tem_pkg::CONS_W-1:0]   o_consumption_c
);
    // coming out of reset: no result waiting, FIFO has room
    `TEM_ASSERT_NOW(a_reset_clear, $rose(i_rst_n), empty && !full)

    // a waiting result word holds until popped
    `TEM_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(o_power_w) && $stable(o_consumed_mj) && $stable(o_consumption_c))

    // the FIFO only fills on a push
    `TEM_ASSERT_NEXT(a_full_needs_push, !full && !push, !full)

    // power saturates at +-500000 W
    `TEM_ASSERT_NOW(a_power_range, !empty, (o_power_w <= 20'sd500000) && (o_power_w >= -20'sd500000))

    // consumption saturates at +-1000000
    `TEM_ASSERT_NOW(a_cons_range, !empty, (o_consumption_c <= 21'sd1000000) && (o_consumption_c >= -21'sd1000000))

endmodule

bind traction_energy_meter tem_checker u_tem_checker (.*);

`default_nettype wire
